// File: rtl/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// shared types and constants for the integer to radix ascii converter
// ----------------------------------------------------------------------------
package itra_pkg;

    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int BASE_W      = 5;
    localparam int MIN_W       = 6;
    localparam int CNT_W       = 6;
    localparam int MAX_CHARS   = 64;
    localparam int IN_VALUE_W  = 64;
    localparam int MIN_LSB     = IN_VALUE_W;
    localparam int S_TDATA_W   = 72;
    localparam int ALPHA_W     = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
    localparam logic [CHAR_W-1:0] MINUS_CHAR   = 8'd45;
    localparam logic [BASE_W-1:0] DECIMAL_BASE = 5'd10;
    localparam logic [BASE_W-1:0] MIN_BASE     = 5'd2;

    localparam logic [1:0] REG_RADIX      = 2'd0;
    localparam logic [1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]  RADIX_RESET      = 5'd16;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h6665646362613938;

    typedef struct packed {
        logic              unsigned_mode;
        logic              negative;
        logic [BASE_W-1:0] base;
        logic [MIN_W-1:0]  min_digits;
    } job_ctrl_t;

endpackage

// File: rtl/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// renders a 64-bit value as ascii digits in signed decimal or a set radix
// ----------------------------------------------------------------------------
// channel  | direction | payload
// s_       | in        | tdata value[63:0] min_digits[69:64], tuser action
// m_       | out       | tdata out_char[7:0], tlast last
// apb      | in/out    | radix @0x00, digit_alphabet_low @0x08, _high @0x10
//
// each item is loaded, then each digit is taken by the byte-serial divider,
// which steps over each significant byte of the running quotient, and then
// the characters are sent out one by one
// a two-entry job queue lets the next word in while the current one is worked
// a two-entry output fifo keeps characters flowing through m_tready stalls
// reset is synchronous, active low, and clears all control state
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_RADIX   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [itra_pkg::S_TDATA_W-1:0]  s_tdata,   // value[63:0], min_digits[69:64]
    input  logic                            s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [itra_pkg::CHAR_W-1:0]     m_tdata,   // out_char[7:0]
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [itra_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [itra_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [itra_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import itra_pkg::*;

    logic [BASE_W-1:0]      radix_reg;
    logic [ALPHA_W-1:0]     alpha_low_reg;
    logic [ALPHA_W-1:0]     alpha_high_reg;
    logic                   cfg_wr;
    logic [1:0]             reg_sel;

    logic                   q_full, q_push, q_empty, q_pop;
    job_ctrl_t              push_ctrl, head_ctrl;
    logic [VALUE_WIDTH-1:0] push_mag, head_mag;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= RADIX_RESET;
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_RADIX:      radix_reg      <= pwdata[BASE_W-1:0];
                REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_RADIX:      prdata = CFG_DATA_W'(radix_reg);
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            default:        prdata = '0;
        endcase
    end

    itra_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .radix    (radix_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctrl   (push_ctrl),
        .q_mag    (push_mag)
    );

    itra_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_ctrl (push_ctrl),
        .push_mag  (push_mag),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_ctrl (head_ctrl),
        .head_mag  (head_mag)
    );

    itra_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (!q_empty),
        .job_ctrl      (head_ctrl),
        .job_mag       (head_mag),
        .job_pop       (q_pop),
        .alphabet_low  (alpha_low_reg),
        .alphabet_high (alpha_high_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// File: rtl/itra_front.sv
// ----------------------------------------------------------------------------
// itra_front
// accepts input words, works out sign, magnitude, base and minimum digit count
// ----------------------------------------------------------------------------
module itra_front #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_RADIX   = 16
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [itra_pkg::S_TDATA_W-1:0] s_tdata,   // value[63:0], min_digits[69:64]
    input  logic                           s_tuser,   // action
    input  logic [itra_pkg::BASE_W-1:0]    radix,
    input  logic                           q_full,
    output logic                           q_push,
    output itra_pkg::job_ctrl_t            q_ctrl,
    output logic [VALUE_WIDTH-1:0]         q_mag
);
    import itra_pkg::*;

    logic [VALUE_WIDTH-1:0] v;
    logic [MIN_W-1:0]       min_in;
    logic                   negative;
    logic [BASE_W-1:0]      radix_sat;

    assign v        = s_tdata[VALUE_WIDTH-1:0];
    assign min_in   = s_tdata[MIN_LSB +: MIN_W];
    assign negative = !s_tuser && v[VALUE_WIDTH-1];

    always_comb begin
        if (radix < MIN_BASE) begin
            radix_sat = MIN_BASE;
        end else if (radix > BASE_W'(MAX_RADIX)) begin
            radix_sat = BASE_W'(MAX_RADIX);
        end else begin
            radix_sat = radix;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_ctrl.unsigned_mode = s_tuser;
        q_ctrl.negative      = negative;
        q_ctrl.base          = s_tuser ? radix_sat : DECIMAL_BASE;
        q_ctrl.min_digits    = (min_in == '0) ? MIN_W'(1) : min_in;
    end

    assign q_mag = negative ? (~v + VALUE_WIDTH'(1)) : v;

endmodule

// File: rtl/itra_queue.sv
// ----------------------------------------------------------------------------
// itra_queue
// two-entry job queue between the front and the back end
// ----------------------------------------------------------------------------
module itra_queue #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  itra_pkg::job_ctrl_t    push_ctrl,
    input  logic [VALUE_WIDTH-1:0] push_mag,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output itra_pkg::job_ctrl_t    head_ctrl,
    output logic [VALUE_WIDTH-1:0] head_mag
);
    import itra_pkg::*;

    job_ctrl_t              ctrl_q [2];
    logic [VALUE_WIDTH-1:0] mag_q  [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign head_ctrl = ctrl_q[rd_ptr_reg];
    assign head_mag  = mag_q[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_q[wr_ptr_reg] <= push_ctrl;
            mag_q[wr_ptr_reg]  <= push_mag;
        end
    end

endmodule

// File: rtl/itra_back.sv
// ----------------------------------------------------------------------------
// itra_back
// digit extraction by byte-serial division, digit store and character output
// ----------------------------------------------------------------------------
module itra_back #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    input  itra_pkg::job_ctrl_t          job_ctrl,
    input  logic [VALUE_WIDTH-1:0]       job_mag,
    output logic                         job_pop,
    input  logic [itra_pkg::ALPHA_W-1:0] alphabet_low,
    input  logic [itra_pkg::ALPHA_W-1:0] alphabet_high,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itra_pkg::CHAR_W-1:0]  m_tdata,   // out_char
    output logic                         m_tlast
);
    import itra_pkg::*;

    localparam int NCHUNK = (VALUE_WIDTH + 7) / 8;
    localparam int PW     = NCHUNK * 8;
    localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                state_reg, state_next;
    job_ctrl_t                 ctrl_reg, ctrl_next;
    logic [NCHUNK-1:0][7:0]    q_reg, q_next;
    logic [DIGIT_W-1:0]        rem_reg, rem_next;
    logic [CIDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]          ndig_reg, ndig_next;
    logic [CNT_W-1:0]          ptr_reg, ptr_next;
    logic                      sign_pend_reg, sign_pend_next;

    logic [NCHUNK-1:0][7:0]    load_val;
    logic [CIDX_W-1:0]         load_top;
    logic                      upper_nz;
    logic [CIDX_W-1:0]         upper_top;
    logic [7:0]                cur_chunk;
    logic [7:0]                qchunk;
    logic [DIGIT_W-1:0]        r;
    logic [DIGIT_W:0]          t;
    logic                      more;

    logic [DIGIT_W-1:0]        digit_mem [MAX_CHARS];
    logic [DIGIT_W-1:0]        mem_q;
    logic                      mem_we;

    logic                      can_issue;
    logic                      issue, issue_sign, issue_last;
    logic                      infl_reg, infl_sign_reg, infl_last_reg, infl_mode_reg;
    logic [15:0][7:0]          alpha;
    logic [CHAR_W-1:0]         push_char;

    logic [CHAR_W-1:0]         ofifo_char [2];
    logic                      ofifo_last [2];
    logic                      of_wr_reg, of_rd_reg;
    logic [1:0]                of_cnt_reg, of_cnt_next;
    logic                      pop;

    // divider front: leading significant byte of a fresh value
    assign load_val = PW'(job_mag);

    always_comb begin
        load_top = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            if (load_val[c] != 8'd0) begin
                load_top = CIDX_W'(c);
            end
        end
    end

    always_comb begin
        upper_nz  = 1'b0;
        upper_top = '0;
        for (int c = 1; c < NCHUNK; c++) begin
            if (q_reg[c] != 8'd0) begin
                upper_nz  = 1'b1;
                upper_top = CIDX_W'(c);
            end
        end
    end

    // eight restoring division steps on one byte
    always_comb begin
        cur_chunk = q_reg[idx_reg];
        r         = rem_reg;
        qchunk    = '0;
        t         = '0;
        for (int b = 7; b >= 0; b--) begin
            t = {r, cur_chunk[b]};
            if (t >= ctrl_reg.base) begin
                t         = t - ctrl_reg.base;
                qchunk[b] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
    end

    assign more = (ndig_reg != CNT_W'(MAX_CHARS - 1)) &&
                  (((7'(ndig_reg) + 7'd1) < 7'(ctrl_reg.min_digits)) ||
                   upper_nz || (qchunk != 8'd0));

    assign pop       = m_tvalid && m_tready;
    assign can_issue = ((2'(of_cnt_reg) + 2'(infl_reg)) < 2'd2) || pop;

    always_comb begin
        state_next     = state_reg;
        ctrl_next      = ctrl_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        ndig_next      = ndig_reg;
        ptr_next       = ptr_reg;
        sign_pend_next = sign_pend_reg;
        mem_we         = 1'b0;
        job_pop        = 1'b0;
        issue          = 1'b0;
        issue_sign     = 1'b0;
        issue_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    ctrl_next  = job_ctrl;
                    q_next     = load_val;
                    rem_next   = '0;
                    idx_next   = load_top;
                    ndig_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                q_next[idx_reg] = qchunk;
                if (idx_reg == '0) begin
                    mem_we    = 1'b1;
                    rem_next  = '0;
                    ndig_next = ndig_reg + CNT_W'(1);
                    if (more) begin
                        idx_next = upper_top;
                    end else begin
                        ptr_next       = ndig_reg;
                        sign_pend_next = ctrl_reg.negative;
                        state_next     = ST_EMIT;
                    end
                end else begin
                    idx_next = idx_reg - CIDX_W'(1);
                    rem_next = r;
                end
            end
            ST_EMIT: begin
                if (can_issue) begin
                    issue = 1'b1;
                    if (sign_pend_reg) begin
                        issue_sign     = 1'b1;
                        sign_pend_next = 1'b0;
                    end else begin
                        issue_last = (ptr_reg == '0);
                        if (ptr_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            ptr_next = ptr_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sign_pend_reg <= 1'b0;
            infl_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sign_pend_reg <= sign_pend_next;
            infl_reg      <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg      <= ctrl_next;
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        idx_reg       <= idx_next;
        ndig_reg      <= ndig_next;
        ptr_reg       <= ptr_next;
        infl_sign_reg <= issue_sign;
        infl_last_reg <= issue_last;
        infl_mode_reg <= ctrl_reg.unsigned_mode;
    end

    // digit store, written lsd first, read back msd first
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[ndig_reg] <= r;
        end
        mem_q <= digit_mem[ptr_reg];
    end

    assign alpha = {alphabet_high, alphabet_low};

    always_comb begin
        if (infl_sign_reg) begin
            push_char = MINUS_CHAR;
        end else if (infl_mode_reg) begin
            push_char = alpha[mem_q];
        end else begin
            push_char = CHAR_W'(mem_q) + ASCII_ZERO;
        end
    end

    // output skid fifo
    assign of_cnt_next = of_cnt_reg + 2'(infl_reg) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            of_wr_reg  <= 1'b0;
            of_rd_reg  <= 1'b0;
            of_cnt_reg <= 2'd0;
        end else begin
            of_cnt_reg <= of_cnt_next;
            if (infl_reg) begin
                of_wr_reg <= !of_wr_reg;
            end
            if (pop) begin
                of_rd_reg <= !of_rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (infl_reg) begin
            ofifo_char[of_wr_reg] <= push_char;
            ofifo_last[of_wr_reg] <= infl_last_reg;
        end
    end

    assign m_tvalid = (of_cnt_reg != 2'd0);
    assign m_tdata  = ofifo_char[of_rd_reg];
    assign m_tlast  = ofifo_last[of_rd_reg];

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (3'(of_cnt_reg) + 3'(infl_reg)) <= 3'd2)
        else $error("output fifo overrun");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (5'(rem_reg) < ctrl_reg.base))
        else $error("remainder not below base");

    a_issue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        infl_reg |-> ($past(state_reg) == ST_EMIT))
        else $error("character issued outside emit");

    a_emit_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && ($past(state_reg) == ST_DIV))
            |-> ($past(idx_reg) == '0))
        else $error("emit entered mid division");

endmodule

// File: dv/integer_to_radix_ascii_tb.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_tb
// self-checking bench for the integer to radix ascii converter
// ----------------------------------------------------------------------------
// numbers go in on the s_ stream and every character coming back on m_ is
// checked against a local renderer that tracks the radix and alphabet
// registers; directed cases cover the field extremes, sign handling, padding
// and radix saturation, then randomised phases run under shifting register
// settings with bursty input and a stalling output, including one long stall
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_tb;
    import itra_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } rendered_char_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;   // value[63:0], min_digits[69:64]
    logic                    s_tuser  = 1'b0; // action
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [CHAR_W-1:0]       m_tdata;         // out_char[7:0]
    logic                    m_tlast;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    logic [BASE_W-1:0]       cfg_radix     = RADIX_RESET;
    logic [ALPHA_W-1:0]      cfg_alpha_low  = ALPHA_LOW_RESET;
    logic [ALPHA_W-1:0]      cfg_alpha_high = ALPHA_HIGH_RESET;

    rendered_char_t          expected_chars[$];
    int                      errors      = 0;
    int                      numbers_in  = 0;
    int                      chars_seen  = 0;
    int                      reg_writes  = 0;
    int                      cycle_count = 0;
    int                      burst_left  = 0;
    int                      hold_left   = 0;

    integer_to_radix_ascii DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars outstanding", cycle_count,
                     expected_chars.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    // renders one number into the queue of expected characters
    task automatic render_expected(input logic action, input logic [63:0] value,
                                   input logic [MIN_W-1:0] min_digits);
        logic [63:0]        mag;
        logic [BASE_W-1:0]  base;
        logic [DIGIT_W-1:0] digits[MAX_CHARS];
        logic [CHAR_W-1:0]  chars[$];
        logic [ALPHA_W-1:0] alpha;
        logic               negative;
        rendered_char_t     rc;
        int                 want;
        int                 ndig;
        int                 i;
        want     = (min_digits == 0) ? 1 : int'(min_digits);
        mag      = value;
        negative = 1'b0;
        if (action) begin
            base = cfg_radix;
            if (base < MIN_BASE)
                base = MIN_BASE;
            if (base > BASE_W'(MAX_CHARS / 4))
                base = BASE_W'(MAX_CHARS / 4);
        end else begin
            base = DECIMAL_BASE;
            if (value[63]) begin
                negative = 1'b1;
                mag      = ~value + 64'd1;
            end
        end
        ndig = 0;
        while (ndig < MAX_CHARS && (ndig < want || mag != 0)) begin
            digits[ndig] = DIGIT_W'(mag % 64'(base));
            mag          = mag / 64'(base);
            ndig++;
        end
        if (negative)
            chars.push_back(MINUS_CHAR);
        for (i = ndig - 1; i >= 0 && chars.size() < MAX_CHARS; i--) begin
            if (action) begin
                alpha = digits[i][3] ? cfg_alpha_high : cfg_alpha_low;
                chars.push_back(alpha[digits[i][2:0]*8 +: 8]);
            end else begin
                chars.push_back(ASCII_ZERO + CHAR_W'(digits[i]));
            end
        end
        for (i = 0; i < chars.size(); i++) begin
            rc.ch   = chars[i];
            rc.last = (i == chars.size() - 1);
            expected_chars.push_back(rc);
        end
    endtask

    // sends one number, then keeps going or takes a gap at the end of a burst
    task automatic offer_number(input logic action, input logic [63:0] value,
                                input logic [MIN_W-1:0] min_digits);
        if (!s_tvalid)
            s_tvalid <= 1'b1;
        s_tdata <= {2'b00, min_digits, value};
        s_tuser <= action;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        render_expected(action, value, min_digits);
        numbers_in++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_for_drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            REG_RADIX:      cfg_radix      = data[BASE_W-1:0];
            REG_ALPHA_LOW:  cfg_alpha_low  = data;
            REG_ALPHA_HIGH: cfg_alpha_high = data;
            default: ;
        endcase
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_radix(input int r);
        wait_for_drain();
        write_register(REG_RADIX, CFG_DATA_W'(r));
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000));
            2: v = -64'($urandom_range(1, 1000));
            3: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = '1;
                    1: v = 64'h8000_0000_0000_0000;
                    2: v = 64'h7fff_ffff_ffff_ffff;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [MIN_W-1:0] random_min_digits();
        return ($urandom_range(0, 5) == 0) ? MIN_W'($urandom_range(0, 63))
                                           : MIN_W'($urandom_range(0, 8));
    endfunction

    // receiver: open and shut runs of its own, plus a long hold on request
    initial begin
        int open_left;
        int shut_left;
        open_left = 0;
        shut_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (open_left > 0) begin
                open_left--;
                m_tready <= 1'b1;
            end else if (shut_left > 0) begin
                shut_left--;
                m_tready <= 1'b0;
            end else begin
                open_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 8);
                shut_left = $urandom_range(0, 4);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : char_check
        rendered_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b", m_tdata, m_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last)
                    report_mismatch($sformatf("char 0x%02h last %0b, wanted 0x%02h last %0b",
                                              m_tdata, m_tlast, want.ch, want.last));
            end
        end
    end

    task automatic test_signed_decimal();
        offer_number(1'b0, 64'd0, 6'd0);
        offer_number(1'b0, 64'd0, 6'd63);
        offer_number(1'b0, 64'd1, 6'd1);
        offer_number(1'b0, '1, 6'd0);
        offer_number(1'b0, 64'h7fff_ffff_ffff_ffff, 6'd0);
        offer_number(1'b0, 64'h8000_0000_0000_0000, 6'd0);
        offer_number(1'b0, -64'd5, 6'd63);
        offer_number(1'b0, 64'd12345, 6'd8);
    endtask

    task automatic test_reset_radix();
        offer_number(1'b1, '1, 6'd0);
        offer_number(1'b1, 64'd0, 6'd0);
        offer_number(1'b1, 64'h0123_4567_89ab_cdef, 6'd20);
    endtask

    // includes the saturating settings below two and above sixteen
    task automatic test_radix_range();
        set_radix(2);
        offer_number(1'b1, '1, 6'd0);
        set_radix(0);
        offer_number(1'b1, 64'd5, 6'd0);
        set_radix(1);
        offer_number(1'b1, 64'd0, 6'd0);
        set_radix(17);
        offer_number(1'b1, '1, 6'd0);
        set_radix(31);
        offer_number(1'b1, 64'hdead_beef, 6'd3);
        set_radix(10);
        offer_number(1'b1, '1, 6'd0);
        set_radix(3);
        offer_number(1'b1, 64'd100, 6'd10);
    endtask

    task automatic test_custom_alphabet();
        set_radix(16);
        write_register(REG_ALPHA_LOW, '0);
        write_register(REG_ALPHA_HIGH, '1);
        offer_number(1'b1, 64'hfedc_ba98_7654_3210, 6'd0);
        wait_for_drain();
        write_register(REG_ALPHA_LOW, {$urandom, $urandom});
        write_register(REG_ALPHA_HIGH, {$urandom, $urandom});
        offer_number(1'b1, 64'h0123_4567_89ab_cdef, 6'd0);
        offer_number(1'b0, -64'd987654321, 6'd12);
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        for (phase = 0; phase < 5; phase++) begin
            wait_for_drain();
            if (phase == 0)
                write_register(REG_RADIX, CFG_DATA_W'(10));
            else if ($urandom_range(0, 3) == 0)
                write_register(REG_RADIX, CFG_DATA_W'($urandom_range(0, 31)));
            else
                write_register(REG_RADIX, CFG_DATA_W'($urandom_range(2, 16)));
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                write_register(REG_ALPHA_LOW, ALPHA_LOW_RESET);
                write_register(REG_ALPHA_HIGH, ALPHA_HIGH_RESET);
            end else begin
                write_register(REG_ALPHA_LOW, {$urandom, $urandom});
                write_register(REG_ALPHA_HIGH, {$urandom, $urandom});
            end
            for (n = 0; n < 25; n++)
                offer_number(1'($urandom_range(0, 1)), random_value(), random_min_digits());
        end
    endtask

    // output held off long enough that the job queue fills and s_tready drops
    task automatic test_output_hold();
        int n;
        wait_for_drain();
        hold_left = 700;
        burst_left = 20;
        for (n = 0; n < 12; n++)
            offer_number(1'($urandom_range(0, 1)), random_value(), random_min_digits());
        wait_for_drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_signed_decimal();
        test_reset_radix();
        test_radix_range();
        test_custom_alphabet();
        test_random_phases();
        test_output_hold();
        wait_for_drain();
        repeat (40) @(posedge aclk);
        $display("covered %0d numbers and %0d characters over %0d register writes",
                 numbers_in, chars_seen, reg_writes);
        $display("signed and radix modes, saturated radix, custom alphabets, long output stall");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
